@@ sv/vec3_fixed_point_alu_macros.svh @@
// Assertion macros for the vec3 fixed-point ALU checker.
// Expect signals clk and rst_n in the scope of use.
`ifndef VEC3_FIXED_POINT_ALU_MACROS_SVH
`define VEC3_FIXED_POINT_ALU_MACROS_SVH

// same-cycle implication
`define VFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vfa_pkg.sv @@
// Package for the vec3 fixed-point ALU: opcodes, pipeline constants,
// shared types and saturation/rounding helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vfa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LANES         = 3;
  localparam int SQRT_STEPS    = 32;
  localparam int QBITS         = 33;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_CROSS = 4'd4;
  localparam logic [3:0] OP_DIV   = 4'd5;
  localparam logic [3:0] OP_DOT   = 4'd6;
  localparam logic [3:0] OP_LEN   = 4'd7;
  localparam logic [3:0] OP_NORM  = 4'd8;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef logic [LANES-1:0][31:0] vec_t;

  typedef struct packed {
    logic [3:0]  op;
    vec_t        a;
    vec_t        b;
    logic [31:0] s;
  } req_t;

  typedef struct packed {
    logic [3:0]  op;
    vec_t        a;
    logic [31:0] s;
    vec_t        r;
    logic [31:0] sc;
    logic        sat;
    logic        dz;
  } item_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [66:0] v);
    sat_t res;
    if (v > 67'sh7FFF_FFFF) begin
      res = '{sat: 1'b1, val: POS_MAX};
    end else if (v < -67'sh8000_0000) begin
      res = '{sat: 1'b1, val: NEG_MAX};
    end else begin
      res = '{sat: 1'b0, val: v[31:0]};
    end
    return res;
  endfunction

  // floor((x + 2^(f-1)) / 2^f)
  function automatic logic signed [66:0] rnd_shift(input logic signed [66:0] x, input int f);
    logic signed [66:0] t;
    t = x + (67'sd1 <<< (f - 1));
    return t >>> f;
  endfunction

endpackage

`default_nettype wire

@@ sv/vfa_if.sv @@
// Valid/ready channel interfaces for request and result transactions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface vfa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [31:0] a_x;
  logic [31:0] a_y;
  logic [31:0] a_z;
  logic [31:0] b_x;
  logic [31:0] b_y;
  logic [31:0] b_z;
  logic [31:0] scale_factor;

  modport source(output valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                 input ready);
  modport sink(input valid, req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
               output ready);
endinterface

interface vfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [31:0] res_z;
  logic [31:0] res_scalar;
  logic        saturated;
  logic        divide_by_zero;

  modport source(output valid, res_x, res_y, res_z, res_scalar, saturated, divide_by_zero,
                 input ready);
  modport sink(input valid, res_x, res_y, res_z, res_scalar, saturated, divide_by_zero,
               output ready);
endinterface

`default_nettype wire

@@ sv/vfa_mul_lane.sv @@
// One multiplier lane: selects operands by opcode and registers two products.
// Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_mul_lane #(
  parameter int LANE = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic [3:0]         op,
  input  vfa_pkg::vec_t      a_i,
  input  vfa_pkg::vec_t      b_i,
  input  logic [31:0]        s_i,
  output logic signed [63:0] p0_r,
  output logic signed [63:0] p1_r
);
  import vfa_pkg::*;

  localparam int J = (LANE + 1) % LANES;
  localparam int K = (LANE + 2) % LANES;

  logic signed [31:0] m0a, m0b, m1a, m1b;
  logic signed [63:0] p0_nxt, p1_nxt;

  always_comb begin
    m0a = '0;
    m0b = '0;
    m1a = '0;
    m1b = '0;
    case (op)
      OP_SCALE: begin
        m0a = a_i[LANE];
        m0b = s_i;
      end
      OP_CROSS: begin
        m0a = a_i[J];
        m0b = b_i[K];
        m1a = a_i[K];
        m1b = b_i[J];
      end
      OP_DOT: begin
        m0a = a_i[LANE];
        m0b = b_i[LANE];
      end
      OP_LEN, OP_NORM: begin
        m0a = a_i[LANE];
        m0b = a_i[LANE];
      end
      default: ;
    endcase
    p0_nxt = m0a * m0b;
    p1_nxt = m1a * m1b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/vfa_merge.sv @@
// Merge stage: combines lane products, rounds and saturates the direct results.
// Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_merge #(
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  vfa_pkg::req_t      req_i,
  input  logic signed [63:0] p0_i [vfa_pkg::LANES],
  input  logic signed [63:0] p1_i [vfa_pkg::LANES],
  output vfa_pkg::item_t     item_r,
  output logic [63:0]        sumsq_r
);
  import vfa_pkg::*;

  item_t              it_nxt;
  logic signed [66:0] t [LANES];
  logic signed [66:0] dsum;
  sat_t               sv;

  always_comb begin
    it_nxt    = '0;
    it_nxt.op = req_i.op;
    it_nxt.a  = req_i.a;
    it_nxt.s  = req_i.s;
    dsum      = '0;
    sv        = '0;
    for (int l = 0; l < LANES; l++) begin
      t[l] = 67'(p0_i[l]) - 67'(p1_i[l]);
      dsum = dsum + t[l];
    end
    case (req_i.op)
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int l = 0; l < LANES; l++) begin
          if (req_i.op == OP_ADD) begin
            sv = sat32(67'($signed(req_i.a[l])) + 67'($signed(req_i.b[l])));
          end else if (req_i.op == OP_SUB) begin
            sv = sat32(67'($signed(req_i.a[l])) - 67'($signed(req_i.b[l])));
          end else begin
            sv = sat32(67'sd0 - 67'($signed(req_i.a[l])));
          end
          it_nxt.r[l] = sv.val;
          it_nxt.sat  = it_nxt.sat | sv.sat;
        end
      end
      OP_SCALE, OP_CROSS: begin
        for (int l = 0; l < LANES; l++) begin
          sv          = sat32(rnd_shift(t[l], FRAC_BITS));
          it_nxt.r[l] = sv.val;
          it_nxt.sat  = it_nxt.sat | sv.sat;
        end
      end
      OP_DOT: begin
        sv         = sat32(rnd_shift(dsum, FRAC_BITS));
        it_nxt.sc  = sv.val;
        it_nxt.sat = sv.sat;
      end
      OP_DIV: begin
        if (req_i.s == '0) begin
          it_nxt.dz = 1'b1;
          for (int l = 0; l < LANES; l++) begin
            if (req_i.a[l][31]) begin
              it_nxt.r[l] = NEG_MAX;
            end else if (req_i.a[l] != '0) begin
              it_nxt.r[l] = POS_MAX;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r  <= it_nxt;
      sumsq_r <= dsum[63:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/vfa_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with the
// transaction carried alongside. Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_sqrt (
  input  logic           clk,
  input  logic           en,
  input  vfa_pkg::item_t item_i,
  input  logic [63:0]    num_i,
  output vfa_pkg::item_t item_o,
  output logic [31:0]    root_o,
  output logic [32:0]    rem_o
);
  import vfa_pkg::*;

  logic [63:0] n_r   [SQRT_STEPS];
  logic [63:0] r_r   [SQRT_STEPS];
  item_t       it_r  [SQRT_STEPS];
  logic [63:0] n_nxt [SQRT_STEPS];
  logic [63:0] r_nxt [SQRT_STEPS];

  always_comb begin
    logic [63:0] ni, ri, bitv, trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        ni = num_i;
        ri = '0;
      end else begin
        ni = n_r[k-1];
        ri = r_r[k-1];
      end
      bitv  = 64'd1 << (62 - 2 * k);
      trial = ri + bitv;
      if (ni >= trial) begin
        n_nxt[k] = ni - trial;
        r_nxt[k] = (ri >> 1) + bitv;
      end else begin
        n_nxt[k] = ni;
        r_nxt[k] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r[0] <= item_i;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        n_r[k] <= n_nxt[k];
        r_r[k] <= r_nxt[k];
        if (k > 0) begin
          it_r[k] <= it_r[k-1];
        end
      end
    end
  end

  assign item_o = it_r[SQRT_STEPS-1];
  assign root_o = r_r[SQRT_STEPS-1][31:0];
  assign rem_o  = n_r[SQRT_STEPS-1][32:0];

endmodule

`default_nettype wire

@@ sv/vfa_div_lane.sv @@
// Pipelined fixed-point divider lane: round(a * 2^F / d), ties away from
// zero, saturated to 32 bits; one quotient bit per stage. Depends on vfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfa_div_lane #(
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a_i,
  input  logic [31:0] d_i,
  input  logic        dneg_i,
  output logic [31:0] q_r,
  output logic        sat_r
);
  import vfa_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = 32 + QBITS;

  logic [NW-1:0]    n_r    [QBITS+1];
  logic [31:0]      d_r    [QBITS+1];
  logic             neg_r  [QBITS+1];
  logic             ovf_r  [QBITS+1];
  logic [32:0]      rem_r  [QBITS+1];
  logic [QBITS-1:0] qt_r   [QBITS+1];
  logic [32:0]      rem_nxt[QBITS];
  logic [QBITS-1:0] qt_nxt [QBITS];

  logic [31:0]   ua;
  logic [NW-1:0] n0;
  logic          rnd;
  logic [33:0]   mag;
  logic [31:0]   q_nxt;
  logic          sat_nxt;

  always_comb begin
    ua = a_i[31] ? (32'd0 - a_i) : a_i;
    n0 = {ua, {FRAC_BITS{1'b0}}};
  end

  always_comb begin
    logic [33:0] rem2;
    logic        ge;
    for (int s = 0; s < QBITS; s++) begin
      rem2       = {rem_r[s], n_r[s][QBITS-1-s]};
      ge         = rem2 >= 34'(d_r[s]);
      rem_nxt[s] = ge ? 33'(rem2 - 34'(d_r[s])) : rem2[32:0];
      qt_nxt[s]  = {qt_r[s][QBITS-2:0], ge};
    end
  end

  always_comb begin
    rnd     = {rem_r[QBITS], 1'b0} >= 34'(d_r[QBITS]);
    mag     = 34'(qt_r[QBITS]) + 34'(rnd);
    sat_nxt = 1'b0;
    q_nxt   = '0;
    if (ovf_r[QBITS]) begin
      sat_nxt = 1'b1;
      q_nxt   = neg_r[QBITS] ? NEG_MAX : POS_MAX;
    end else if (!neg_r[QBITS] && mag > 34'(POS_MAX)) begin
      sat_nxt = 1'b1;
      q_nxt   = POS_MAX;
    end else if (neg_r[QBITS] && mag > 34'(NEG_MAX)) begin
      sat_nxt = 1'b1;
      q_nxt   = NEG_MAX;
    end else begin
      q_nxt = neg_r[QBITS] ? (32'd0 - mag[31:0]) : mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= n0;
      d_r[0]   <= d_i;
      neg_r[0] <= a_i[31] ^ dneg_i;
      ovf_r[0] <= CW'(n0) >= {d_i, {QBITS{1'b0}}};
      rem_r[0] <= 33'(n0 >> QBITS);
      qt_r[0]  <= '0;
      for (int s = 0; s < QBITS; s++) begin
        n_r[s+1]   <= n_r[s];
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
        rem_r[s+1] <= rem_nxt[s];
        qt_r[s+1]  <= qt_nxt[s];
      end
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/vec3_fixed_point_alu.sv @@
// Top level of the vec3 fixed-point ALU: multiplier lanes, merge, square root,
// divider lanes and output register. Depends on vfa_pkg, vfa_if, vfa_mul_lane, vfa_merge, vfa_sqrt and vfa_div_lane.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      req_type, a_x..b_z, scale_factor
//   out_ch    out  valid/ready      res_x, res_y, res_z, res_scalar, flags
//   cfg_*     in   cfg_wr_en        cfg_wr_data (unit_min_length)
//
// One transaction per cycle while the result is not stalled; results pass through the
// 32-stage square root followed by the 35-stage divider lanes.
// Reset clears the pipeline valid bits, the output valid and unit_min_length.
// A stalled result holds the whole pipeline; in_ch.ready drops then and in reset.
`timescale 1ns / 1ps
`default_nettype none

module vec3_fixed_point_alu #(
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  vfa_in_if.sink      in_ch,
  vfa_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);
  import vfa_pkg::*;

  localparam int DIV_LAT = QBITS + 2;
  localparam int LAT     = 2 + SQRT_STEPS + 1 + DIV_LAT;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [30:0]    min_len_r;
  logic           out_valid_r;

  vec_t               a_in, b_in;
  req_t               req_r;
  logic signed [63:0] p0 [LANES];
  logic signed [63:0] p1 [LANES];
  item_t              item_m, item_s;
  logic [63:0]        sumsq_m;
  logic [31:0]        root_s;
  logic [32:0]        rem_s;

  logic [32:0] len;
  item_t       pre_nxt, pre_r;
  logic        go_nxt, go_r;
  logic [31:0] d_nxt, d_r;
  logic        dneg_nxt, dneg_r;

  item_t       item_dl_r [DIV_LAT];
  logic        go_dl_r   [DIV_LAT];
  logic [31:0] q   [LANES];
  logic        qs  [LANES];
  item_t       fin;

  logic [31:0] res_x_r, res_y_r, res_z_r, res_sc_r;
  logic        sat_r, dz_r;

  assign en        = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  assign a_in = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign b_in = {in_ch.b_z, in_ch.b_y, in_ch.b_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      min_len_r   <= '0;
    end else begin
      if (en) begin
        vld_r       <= {vld_r[LAT-2:0], in_ch.valid};
        out_valid_r <= vld_r[LAT-1];
      end
      if (cfg_wr_en) begin
        min_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= '{op: in_ch.req_type, a: a_in, b: b_in, s: in_ch.scale_factor};
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_mul
    vfa_mul_lane #(.LANE(g)) u_mul (
      .clk (clk),
      .en  (en),
      .op  (in_ch.req_type),
      .a_i (a_in),
      .b_i (b_in),
      .s_i (in_ch.scale_factor),
      .p0_r(p0[g]),
      .p1_r(p1[g])
    );
  end

  vfa_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk    (clk),
    .en     (en),
    .req_i  (req_r),
    .p0_i   (p0),
    .p1_i   (p1),
    .item_r (item_m),
    .sumsq_r(sumsq_m)
  );

  vfa_sqrt u_sqrt (
    .clk   (clk),
    .en    (en),
    .item_i(item_m),
    .num_i (sumsq_m),
    .item_o(item_s),
    .root_o(root_s),
    .rem_o (rem_s)
  );

  always_comb begin
    len      = (rem_s > 33'(root_s)) ? (33'(root_s) + 33'd1) : 33'(root_s);
    pre_nxt  = item_s;
    go_nxt   = 1'b0;
    d_nxt    = '0;
    dneg_nxt = 1'b0;
    case (item_s.op)
      OP_LEN: begin
        if (len > 33'(POS_MAX)) begin
          pre_nxt.sc  = POS_MAX;
          pre_nxt.sat = 1'b1;
        end else begin
          pre_nxt.sc = len[31:0];
        end
      end
      OP_NORM: begin
        if (len > 33'(min_len_r)) begin
          go_nxt = 1'b1;
          d_nxt  = len[31:0];
        end
      end
      OP_DIV: begin
        if (item_s.s != '0) begin
          go_nxt   = 1'b1;
          dneg_nxt = item_s.s[31];
          d_nxt    = item_s.s[31] ? (32'd0 - item_s.s) : item_s.s;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r  <= pre_nxt;
      go_r   <= go_nxt;
      d_r    <= d_nxt;
      dneg_r <= dneg_nxt;
      item_dl_r[0] <= pre_r;
      go_dl_r[0]   <= go_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        item_dl_r[k] <= item_dl_r[k-1];
        go_dl_r[k]   <= go_dl_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_div
    vfa_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .a_i   (pre_r.a[g]),
      .d_i   (d_r),
      .dneg_i(dneg_r),
      .q_r   (q[g]),
      .sat_r (qs[g])
    );
  end

  always_comb begin
    fin = item_dl_r[DIV_LAT-1];
    if (go_dl_r[DIV_LAT-1]) begin
      for (int l = 0; l < LANES; l++) begin
        fin.r[l] = q[l];
        fin.sat  = fin.sat | qs[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r  <= fin.r[0];
      res_y_r  <= fin.r[1];
      res_z_r  <= fin.r[2];
      res_sc_r <= fin.sc;
      sat_r    <= fin.sat;
      dz_r     <= fin.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_x          = res_x_r;
  assign out_ch.res_y          = res_y_r;
  assign out_ch.res_z          = res_z_r;
  assign out_ch.res_scalar     = res_sc_r;
  assign out_ch.saturated      = sat_r;
  assign out_ch.divide_by_zero = dz_r;

endmodule

`default_nettype wire

@@ sv/vfa_checker.sv @@
// Port-level checker for the vec3 fixed-point ALU and its bind to the top.
// Depends on vec3_fixed_point_alu_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "vec3_fixed_point_alu_macros.svh"

module vfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] res_x,
  input wire logic [31:0] res_y,
  input wire logic [31:0] res_z,
  input wire logic [31:0] res_scalar,
  input wire logic        saturated,
  input wire logic        divide_by_zero
);

  `VFA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `VFA_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(res_x) && $stable(res_y) && $stable(res_z) && $stable(res_scalar), "stalled result changed")
  `VFA_ASSERT_IMP(a_ready_free, !out_valid || out_ready, in_ready, "input blocked with free output")
  `VFA_ASSERT_IMP(a_flags_excl, out_valid, !(saturated && divide_by_zero), "both flags raised")
  `VFA_ASSERT_IMP(a_dz_scalar, out_valid && divide_by_zero, res_scalar == 32'd0, "scalar set on divide by zero")

endmodule

bind vec3_fixed_point_alu vfa_checker u_vfa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .res_x         (out_ch.res_x),
  .res_y         (out_ch.res_y),
  .res_z         (out_ch.res_z),
  .res_scalar    (out_ch.res_scalar),
  .saturated     (out_ch.saturated),
  .divide_by_zero(out_ch.divide_by_zero)
);

`default_nettype wire

@@ tb/vfa_tb_if.sv @@
// Testbench interface file; it declares no interfaces of its own.
// Depends on nothing; the RTL's vfa_if.sv defines the interfaces that the testbench uses.
`timescale 1ns / 1ps

@@ tb/vec3_fixed_point_alu_tb.sv @@
// Testbench for vec3_fixed_point_alu: random and directed vector requests, a queued
// scoreboard with a 128-bit arithmetic predictor. Depends on vfa_pkg and vfa_if.
`timescale 1ns / 1ps

module vec3_fixed_point_alu_tb;
  import vfa_pkg::*;

  typedef struct {
    logic [31:0] x, y, z, sc;
    logic sat, dz;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    logic [30:0] min_len;
    int errors;

    function new();
      min_len = '0;
      errors = 0;
    endfunction

    function automatic logic signed [127:0] clip(logic signed [127:0] v, ref logic sat);
      if (v > 128'sh7FFFFFFF) begin
        sat = 1'b1;
        return 128'sh7FFFFFFF;
      end
      if (v < -128'sh80000000) begin
        sat = 1'b1;
        return -128'sh80000000;
      end
      return v;
    endfunction

    function automatic logic signed [127:0] rnd(logic signed [127:0] p);
      return (p + (128'sd1 <<< 15)) >>> 16;
    endfunction

    function automatic logic signed [127:0] qdiv(logic signed [127:0] a,
                                                 logic signed [127:0] d);
      logic [127:0] ua, ud, q;
      ua = a < 0 ? -a : a;
      ud = d < 0 ? -d : d;
      q = ((ua << 17) + ud) / (ud << 1);
      return ((a < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] sqrt_rnd(logic [127:0] n);
      logic [127:0] r, b;
      r = 0;
      b = 128'd1 << 100;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return n > r ? r + 1 : r;
    endfunction

    function void note_request(logic [3:0] op, logic [31:0] ax, ay, az, bx, by, bz, s);
      logic signed [127:0] a[3], b[3], r[3], sv, sc;
      logic [127:0] len;
      alu_res_t e;
      a[0] = $signed(ax); a[1] = $signed(ay); a[2] = $signed(az);
      b[0] = $signed(bx); b[1] = $signed(by); b[2] = $signed(bz);
      sv = $signed(s);
      r[0] = 0; r[1] = 0; r[2] = 0; sc = 0;
      e.sat = 1'b0; e.dz = 1'b0;
      case (op)
        OP_ADD: for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i], e.sat);
        OP_SUB: for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i], e.sat);
        OP_NEG: for (int i = 0; i < 3; i++) r[i] = clip(-a[i], e.sat);
        OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clip(rnd(a[i] * sv), e.sat);
        OP_CROSS: begin
          r[0] = clip(rnd(a[1] * b[2] - a[2] * b[1]), e.sat);
          r[1] = clip(rnd(a[2] * b[0] - a[0] * b[2]), e.sat);
          r[2] = clip(rnd(a[0] * b[1] - a[1] * b[0]), e.sat);
        end
        OP_DIV: begin
          if (sv == 0) begin
            e.dz = 1'b1;
            for (int i = 0; i < 3; i++)
              r[i] = a[i] > 0 ? 128'sh7FFFFFFF : (a[i] < 0 ? -128'sh80000000 : 0);
          end else begin
            for (int i = 0; i < 3; i++) r[i] = clip(qdiv(a[i], sv), e.sat);
          end
        end
        OP_DOT: sc = clip(rnd(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), e.sat);
        OP_LEN, OP_NORM: begin
          len = sqrt_rnd(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
          if (op == OP_LEN) begin
            sc = clip($signed(len), e.sat);
          end else if (len > min_len) begin
            for (int i = 0; i < 3; i++) r[i] = clip(qdiv(a[i], $signed(len)), e.sat);
          end
        end
        default: ;
      endcase
      e.x = r[0][31:0]; e.y = r[1][31:0]; e.z = r[2][31:0]; e.sc = sc[31:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] x, y, z, sc, logic sat, dz);
      alu_res_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin $error("res_x exp %h got %h", e.x, x); errors++; end
      if (y !== e.y) begin $error("res_y exp %h got %h", e.y, y); errors++; end
      if (z !== e.z) begin $error("res_z exp %h got %h", e.z, z); errors++; end
      if (sc !== e.sc) begin $error("res_scalar exp %h got %h", e.sc, sc); errors++; end
      if (sat !== e.sat) begin $error("saturated exp %b got %b", e.sat, sat); errors++; end
      if (dz !== e.dz) begin $error("divide_by_zero exp %b got %b", e.dz, dz); errors++; end
    endfunction
  endclass

  localparam int LATENCY = 71;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [30:0] cfg_wr_data = '0;
  bit hold_off = 1'b0;
  int n_sent = 0;
  int n_recv = 0;
  alu_scoreboard sb;

  vfa_in_if in_ch ();
  vfa_out_if out_ch ();

  vec3_fixed_point_alu uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
    in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
    in_ch.scale_factor = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      4, 5: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh1FFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [3:0] op, logic [31:0] ax, ay, az, bx, by, bz, s);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= op;
    in_ch.a_x <= ax; in_ch.a_y <= ay; in_ch.a_z <= az;
    in_ch.b_x <= bx; in_ch.b_y <= by; in_ch.b_z <= bz;
    in_ch.scale_factor <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, ax, ay, az, bx, by, bz, s);
    n_sent++;
  endtask

  task automatic send_idle(int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_rand(int gap_max);
    logic [3:0] op;
    op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send(op, rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
         ($urandom_range(0, 9) == 0) ? 32'h0 : rand_val());
    send_idle($urandom_range(0, gap_max));
  endtask

  task automatic drain_and_write(logic [30:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.min_len = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.res_x, out_ch.res_y, out_ch.res_z, out_ch.res_scalar,
                      out_ch.saturated, out_ch.divide_by_zero);
      n_recv++;
    end
  end

  initial begin : receiver
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (n_recv > 300 && n_recv < 360) wait_n = 0;
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : limit
    #50ms;
    $display("FAIL vec3_fixed_point_alu");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 32'hFFFFFFFF, 32'h2, 0);
    send(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h0, 0);
    send(OP_NEG, 32'h80000000, 32'h7FFFFFFF, 32'h0, 0, 0, 0, 0);
    send(OP_SCALE, 32'h7FFFFFFF, 32'h80000000, 32'h00018000, 0, 0, 0, 32'h00020000);
    send(OP_SCALE, 32'h00000001, 32'hFFFFFFFF, 32'h00000003, 0, 0, 0, 32'h00008000);
    send(OP_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0);
    send(OP_CROSS, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
         32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    send(OP_DIV, 32'h00050000, 32'hFFFB0000, 0, 0, 0, 0, 32'h0);
    send(OP_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000003, 0, 0, 0, 32'h00000001);
    send(OP_DIV, 32'h00010000, 32'hFFFF0000, 32'h00000001, 0, 0, 0, 32'h00020000);
    send(OP_DOT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
         32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send(OP_DOT, 32'h00010000, 32'h00020000, 0, 32'h00030000, 32'hFFFF0000, 0, 0);
    send(OP_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
    send(OP_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    send(OP_NORM, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    send(OP_NORM, 0, 0, 0, 0, 0, 0, 0);
    send(OP_NORM, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 0, 0, 0, 0);
    send(4'd9, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
         32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(4'd15, 1, 1, 1, 1, 1, 1, 1);
    // minimum length at the boundary of a 5.0 vector
    drain_and_write(31'h00050000);
    send(OP_NORM, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    send(OP_NORM, 32'h00030000, 32'h00040001, 0, 0, 0, 0, 0);
    send_idle(1);
    drain_and_write(31'h7FFFFFFF);
    for (int i = 0; i < 100; i++) send_rand(4);
    drain_and_write(31'h0);
    // stall the result side while requests keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 200; i++) send_rand(($urandom_range(0, 1) == 0) ? 0 : 4);
    send_idle(1);
    while (sb.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < 150; i++) send_rand(i < 75 ? 4 : 0);
    drain_and_write(31'($urandom));
    for (int i = 0; i < 150; i++) send_rand(4);
    drain_and_write(31'h00010000);
    for (int i = 0; i < 50; i++) send_rand(2);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d requests over all nine operations and five length minimums,", n_sent);
    $display("checked %0d results including a long output stall.", n_recv);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS vec3_fixed_point_alu");
    end else begin
      $display("FAIL vec3_fixed_point_alu");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/vfa_pkg.sv
sv/vfa_if.sv
sv/vfa_mul_lane.sv
sv/vfa_merge.sv
sv/vfa_sqrt.sv
sv/vfa_div_lane.sv
sv/vec3_fixed_point_alu.sv
sv/vfa_checker.sv
tb/vfa_tb_if.sv
tb/vec3_fixed_point_alu_tb.sv
